[hdl/lbc_pkg.sv]
// shared types, codes and constants of the led blink code generator
package lbc_pkg;

    // register widths and reset values
    localparam int COUNT_W     = 8;
    localparam int TIME_W      = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int PHASE_W     = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [TIME_W-1:0] RST_ON_TIME  = 16'd200;
    localparam logic [TIME_W-1:0] RST_GAP_TIME = 16'd2000;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BLINK_COUNT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ON_TIME     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAP_TIME    = 2'd2;

    // phase codes as seen on the result item
    localparam logic [PHASE_W-1:0] PH_START  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_TO_OFF = 2'd1;
    localparam logic [PHASE_W-1:0] PH_TO_ON  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_GAP    = 2'd3;

    // sequencer state, one-hot
    typedef enum logic [3:0] {
        ST_START  = 4'b0001,
        ST_TO_OFF = 4'b0010,
        ST_TO_ON  = 4'b0100,
        ST_GAP    = 4'b1000
    } t_seq_state;

    // configuration write
    typedef struct packed {
        logic                  we;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // result item, led_on in the lowest bit
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               led_on;
    } t_result;

    localparam int RESULT_W = $bits(t_result);

    // sequencer status towards the top level
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               led_on;
        logic               idle_count;
    } t_seq_status;

    // state to phase code
    function automatic logic [PHASE_W-1:0] phase_code(input t_seq_state st);
        logic [PHASE_W-1:0] code;
        case (st)
            ST_START:  code = PH_START;
            ST_TO_OFF: code = PH_TO_OFF;
            ST_TO_ON:  code = PH_TO_ON;
            ST_GAP:    code = PH_GAP;
            default:   code = PH_START;
        endcase
        return code;
    endfunction

endpackage

[hdl/lbc_seq.sv]
// blink sequencer: configuration registers, down-timer and phase state
module lbc_seq import lbc_pkg::*; #(
    parameter int TIMER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg_wr     i_cfg,
    input  logic        i_step,
    input  logic        i_tick,
    output t_result     o_result,
    output t_seq_status o_status
);

    logic [COUNT_W-1:0]    r_blink_count, n_blink_count;
    logic [TIME_W-1:0]     r_on_time, n_on_time;
    logic [TIME_W-1:0]     r_gap_time, n_gap_time;
    t_seq_state            r_state, n_state;
    logic [COUNT_W-1:0]    r_blinks_left, n_blinks_left;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic                  r_led, n_led;

    logic [TIMER_BITS-1:0] w_timer_dec;
    logic                  w_expired;
    logic [TIMER_BITS-1:0] w_on_load;
    logic [TIMER_BITS-1:0] w_gap_load;

    // timing values fitted to the timer width
    assign w_on_load  = TIMER_BITS'(r_on_time);
    assign w_gap_load = TIMER_BITS'(r_gap_time);

    // tick first: a nonzero timer counts down
    assign w_timer_dec = (i_tick && (r_timer != '0)) ? (r_timer - 1'b1) : r_timer;
    assign w_expired   = (w_timer_dec == '0);

    // one evaluation of the sequencer per item
    always_comb begin
        n_blink_count = r_blink_count;
        n_on_time     = r_on_time;
        n_gap_time    = r_gap_time;
        n_state       = r_state;
        n_blinks_left = r_blinks_left;
        n_timer       = r_timer;
        n_led         = r_led;

        if (i_step) begin
            n_timer = w_timer_dec;
            case (r_state)
                ST_START: begin
                    n_blinks_left = r_blink_count;
                    if (r_blink_count != '0) begin
                        n_led         = 1'b1;
                        n_timer       = w_on_load;
                        n_state       = ST_TO_OFF;
                        n_blinks_left = r_blink_count - 1'b1;
                    end
                end
                ST_TO_OFF: begin
                    if (w_expired) begin
                        n_led   = 1'b0;
                        n_timer = w_on_load;
                        n_state = ST_TO_ON;
                    end
                end
                ST_TO_ON: begin
                    if (w_expired) begin
                        if (r_blinks_left != '0) begin
                            n_blinks_left = r_blinks_left - 1'b1;
                            n_timer       = w_on_load;
                            n_state       = ST_TO_OFF;
                            n_led         = 1'b1;
                        end else begin
                            n_timer = w_gap_load;
                            n_state = ST_GAP;
                        end
                    end
                end
                ST_GAP: begin
                    if (w_expired) begin
                        n_state = ST_START;
                    end
                end
                default: begin
                    n_state = ST_START;
                end
            endcase
        end

        // register writes, count write restarts the pattern
        if (i_cfg.we) begin
            case (i_cfg.addr)
                REG_BLINK_COUNT: begin
                    n_blink_count = i_cfg.data[COUNT_W-1:0];
                    n_state       = ST_START;
                end
                REG_ON_TIME:  n_on_time  = i_cfg.data[TIME_W-1:0];
                REG_GAP_TIME: n_gap_time = i_cfg.data[TIME_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_count <= '0;
            r_on_time     <= RST_ON_TIME;
            r_gap_time    <= RST_GAP_TIME;
            r_state       <= ST_START;
            r_blinks_left <= '0;
            r_timer       <= '0;
            r_led         <= 1'b0;
        end else begin
            r_blink_count <= n_blink_count;
            r_on_time     <= n_on_time;
            r_gap_time    <= n_gap_time;
            r_state       <= n_state;
            r_blinks_left <= n_blinks_left;
            r_timer       <= n_timer;
            r_led         <= n_led;
        end
    end

    // result of this evaluation
    assign o_result.led_on = n_led;
    assign o_result.phase  = phase_code(n_state);

    assign o_status.phase      = phase_code(r_state);
    assign o_status.led_on     = r_led;
    assign o_status.idle_count = (r_blink_count == '0);

endmodule

[hdl/lbc_obuf.sv]
// output register with skid stage for result items
module lbc_obuf import lbc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_result i_in_data,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_data
);

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main_data, n_main_data;
    t_result r_skid_data, n_skid_data;
    logic    w_in_fire;

    assign o_in_ready = !r_skid_valid;
    assign w_in_fire  = i_in_valid && !r_skid_valid;

    // refill the output register, park an item in the skid stage on stall
    always_comb begin
        n_main_valid = r_main_valid;
        n_main_data  = r_main_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (!r_main_valid || i_out_ready) begin
            if (r_skid_valid) begin
                n_main_valid = 1'b1;
                n_main_data  = r_skid_data;
                n_skid_valid = 1'b0;
            end else if (w_in_fire) begin
                n_main_valid = 1'b1;
                n_main_data  = i_in_data;
            end else begin
                n_main_valid = 1'b0;
            end
        end else if (w_in_fire) begin
            n_skid_valid = 1'b1;
            n_skid_data  = i_in_data;
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_main_data <= n_main_data;
        r_skid_data <= n_skid_data;
    end

    assign o_out_valid = r_main_valid;
    assign o_out_data  = r_main_data;

endmodule

[hdl/led_blink_code_generator.sv]
// a result item is registered once its input item is accepted, in the skid stage while the output stalls
// throughput: one item per cycle while the skid stage is empty, set by the sequencer update per item
// the output register and skid stage keep input flowing: the skid stage takes one more item on stall
// reset: synchronous, active low; phase start, led off, timer and count zero,
// on_time 200 and gap_time 2000 ticks, no result pending
module led_blink_code_generator import lbc_pkg::*; #(
    parameter int TIMER_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input item: [0] advance_time, [7:1] zero
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result item: [0] led_on, [2:1] phase, [7:3] zero
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // register writes
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    t_cfg_wr     w_cfg;
    t_result     w_result;
    t_result     w_out;
    t_seq_status w_status;
    logic        w_step;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.addr = i_cfg_addr;
    assign w_cfg.data = i_cfg_wdata;

    assign w_step = s_axis_tvalid && s_axis_tready;

    // sequencer
    lbc_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_step   (w_step),
        .i_tick   (s_axis_tdata[0]),
        .o_result (w_result),
        .o_status (w_status)
    );

    // result buffering
    lbc_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_data   (w_result),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (w_out)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - RESULT_W)'(0), w_out};

    // back-pressure only while a result is held
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // after an accepted item a result is always pending next cycle
    a_item_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> m_axis_tvalid)
        else $error("accepted item produced no result");

    // count write sends the sequencer back to start
    a_count_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_addr == REG_BLINK_COUNT)) |=> (w_status.phase == PH_START))
        else $error("count write did not restart the pattern");

    // with a zero count an item leaves the sequencer in start
    a_idle_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && !i_cfg_we && w_status.idle_count && (w_status.phase == PH_START))
        |=> ((w_status.phase == PH_START) && ($past(w_status.led_on) == w_status.led_on)))
        else $error("sequencer left start with zero count");

endmodule

[tb/tb.sv]
// testbench of the led blink code generator: predicted led and phase per item, checked in order
`timescale 1ns / 1ps

module tb;
    import lbc_pkg::*;

    localparam int TIMER_BITS  = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 3;
    localparam int TAIL_WAIT   = 4;
    localparam int HOLD_OFF    = 60;
    localparam int RAND_PHASES = 7;
    localparam int RAND_ITEMS  = 80;

    // index with no register behind it, writes are dropped
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    // predicted registers and sequencer state
    logic [COUNT_W-1:0]    cnt_reg;
    logic [TIME_W-1:0]     on_reg;
    logic [TIME_W-1:0]     gap_reg;
    logic [PHASE_W-1:0]    seq_ph;
    logic [COUNT_W-1:0]    blinks_left;
    logic [TIMER_BITS-1:0] tick_timer;
    logic                  led_lvl;

    // led states still to come out of the block
    t_result     led_states_q[$];
    int          fail_count = 0;
    bit          tx_random = 1'b0;
    bit          rx_random = 1'b1;
    int unsigned hold_request = 0;

    led_blink_code_generator #(
        .TIMER_BITS(TIMER_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // one evaluation of the blink sequencer, optional tick first
    function automatic t_result sequencer_step(input logic tick);
        logic    expired;
        t_result res;
        if (tick && tick_timer != '0)
            tick_timer = tick_timer - 1'b1;
        expired = (tick_timer == '0);
        case (seq_ph)
            PH_START: begin
                blinks_left = cnt_reg;
                if (blinks_left != '0) begin
                    led_lvl     = 1'b1;
                    tick_timer  = TIMER_BITS'(on_reg);
                    seq_ph      = PH_TO_OFF;
                    blinks_left = blinks_left - 1'b1;
                end
            end
            PH_TO_OFF: begin
                if (expired) begin
                    led_lvl    = 1'b0;
                    tick_timer = TIMER_BITS'(on_reg);
                    seq_ph     = PH_TO_ON;
                end
            end
            PH_TO_ON: begin
                if (expired) begin
                    if (blinks_left != '0) begin
                        blinks_left = blinks_left - 1'b1;
                        tick_timer  = TIMER_BITS'(on_reg);
                        seq_ph      = PH_TO_OFF;
                        led_lvl     = 1'b1;
                    end else begin
                        seq_ph     = PH_GAP;
                        tick_timer = TIMER_BITS'(gap_reg);
                    end
                end
            end
            default: begin
                if (expired)
                    seq_ph = PH_START;
            end
        endcase
        res.led_on = led_lvl;
        res.phase  = seq_ph;
        return res;
    endfunction

    // gap length, mostly short and now and then long
    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    endfunction

    // compare one result item with the oldest prediction
    task automatic check_result(input logic [OUT_TDATA_W-1:0] data);
        t_result want;
        t_result got;
        got = t_result'(data[RESULT_W-1:0]);
        if (led_states_q.size() == 0) begin
            $display("%0t: result item %h with nothing pending", $time, data);
            fail_count++;
        end else begin
            want = led_states_q.pop_front();
            if (got.led_on !== want.led_on) begin
                $display("%0t: led_on expected %0b, got %0b", $time, want.led_on, got.led_on);
                fail_count++;
            end
            if (got.phase !== want.phase) begin
                $display("%0t: phase expected %0d, got %0d", $time, want.phase, got.phase);
                fail_count++;
            end
            if (data[OUT_TDATA_W-1:RESULT_W] !== '0) begin
                $display("%0t: padding expected 0, got %h", $time,
                         data[OUT_TDATA_W-1:RESULT_W]);
                fail_count++;
            end
        end
    endtask

    // result side: check accepted items, then choose next tready
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (hold_request != 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && rx_random && $urandom_range(0, 2) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left != 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no item moving on either side and no register write
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // offer one item and predict its result once it is taken
    task automatic send_item(input logic tick);
        int unsigned gap;
        gap = (tx_random && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(tick);
        do @(posedge i_clk); while (!s_axis_tready);
        led_states_q.push_back(sequencer_step(tick));
    endtask

    // stop offering and wait until every result has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (led_states_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // register write, block idle
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (addr)
            REG_BLINK_COUNT: begin
                cnt_reg = data[COUNT_W-1:0];
                seq_ph  = PH_START;
            end
            REG_ON_TIME:  on_reg  = data[TIME_W-1:0];
            REG_GAP_TIME: gap_reg = data[TIME_W-1:0];
            default: ;
        endcase
    endtask

    // count of zero after reset keeps the sequencer in start
    task automatic test_zero_count();
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        wait_drained();
    endtask

    // short full pattern: two blinks then the gap, some evaluations without tick
    task automatic test_blink_pattern();
        write_reg(REG_ON_TIME, 16'd1);
        write_reg(REG_GAP_TIME, 16'd2);
        write_reg(REG_BLINK_COUNT, 16'd2);
        for (int i = 0; i < 12; i++)
            send_item(i % 4 != 3);
        wait_drained();
    endtask

    // dropped index, zero durations, full-scale values and restart while lit
    task automatic test_register_extremes();
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_ON_TIME, 16'd0);
        write_reg(REG_GAP_TIME, 16'd0);
        write_reg(REG_BLINK_COUNT, 16'd255);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        wait_drained();
        write_reg(REG_ON_TIME, 16'hFFFF);
        write_reg(REG_GAP_TIME, 16'hFFFF);
        write_reg(REG_BLINK_COUNT, 16'd1);
        send_item(1'b1);
        send_item(1'b1);
        send_item(1'b0);
        wait_drained();
        write_reg(REG_BLINK_COUNT, 16'd1);
        send_item(1'b1);
        wait_drained();
    endtask

    // receiver holds off while items keep coming, input must stall
    task automatic test_output_stall();
        write_reg(REG_ON_TIME, 16'd2);
        write_reg(REG_GAP_TIME, 16'd3);
        write_reg(REG_BLINK_COUNT, 16'd3);
        tx_random    = 1'b0;
        hold_request = HOLD_OFF;
        for (int i = 0; i < 20; i++)
            send_item($urandom_range(0, 3) != 0);
        wait_drained();
    endtask

    // random settings per phase, random ticks, mostly short timers
    task automatic test_random_patterns();
        logic [CFG_DATA_W-1:0] cnt_val;
        logic [CFG_DATA_W-1:0] on_val;
        logic [CFG_DATA_W-1:0] gap_val;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            tx_random = (ph % 3 != 0);
            rx_random = (ph % 4 != 1);
            case ($urandom_range(0, 9))
                0: cnt_val = '0;
                1: cnt_val = 16'd255;
                default: cnt_val = CFG_DATA_W'($urandom_range(1, 5));
            endcase
            // the upper byte of the count write is dropped by the block
            cnt_val[CFG_DATA_W-1:COUNT_W] = (CFG_DATA_W - COUNT_W)'($urandom);
            on_val  = CFG_DATA_W'(($urandom_range(0, 19) == 0) ? $urandom
                                                                : $urandom_range(0, 3));
            gap_val = CFG_DATA_W'(($urandom_range(0, 19) == 0) ? $urandom
                                                                : $urandom_range(0, 6));
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            write_reg(REG_ON_TIME, on_val);
            write_reg(REG_GAP_TIME, gap_val);
            // sometimes leave the pattern running without a restart
            if (ph == 0 || $urandom_range(0, 3) != 0)
                write_reg(REG_BLINK_COUNT, cnt_val);
            for (int i = 0; i < RAND_ITEMS; i++)
                send_item($urandom_range(0, 3) != 0);
            wait_drained();
        end
    endtask

    // reset, tests in turn, drain and verdict
    initial begin : run_tests
        cnt_reg     = '0;
        on_reg      = RST_ON_TIME;
        gap_reg     = RST_GAP_TIME;
        seq_ph      = PH_START;
        blinks_left = '0;
        tick_timer  = '0;
        led_lvl     = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_count();
        test_blink_pattern();
        test_register_extremes();
        test_output_stall();
        test_random_patterns();
        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0 && led_states_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
